@@ hdl/avr_pkg.sv @@
// shared constants, types and the quarter-wave sine table for the axis vertex rotator
// no dependencies; compiled first

package avr_pkg;

   localparam int COORD_WIDTH      = 16;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int FRAC_BITS        = 14;

   localparam int SIN_W    = FRAC_BITS + 1;
   localparam int TRIG_W   = SIN_W + 1;
   localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int ROM_BITS = SIN_W * (SINE_TABLE_DEPTH + 1);

   localparam int ANGLE_W      = 16;
   localparam int STEP_W       = 16;
   localparam int FULL_TURN    = 36000;
   localparam int QUARTER_TURN = 9000;
   localparam int REM_W        = $clog2(QUARTER_TURN + 1);

   localparam int NUM_MAX     = QUARTER_TURN * SINE_TABLE_DEPTH + QUARTER_TURN / 2;
   localparam int NUM_W       = $clog2(NUM_MAX + 1);
   localparam int RECIP_SHIFT = NUM_W;
   localparam longint unsigned RECIP = (64'd1 << NUM_W) / QUARTER_TURN;
   localparam int RECIP_W     = $clog2(RECIP + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int AXIS_W      = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
   localparam logic [AXIS_W-1:0] AXIS_PASS = 2'd3;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_VERTEX = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_AXIS       = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_STEP = 1'b1;

   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
      logic [ANGLE_W-1:0]            angle;
   } vertex_type;

   // taylor series sine in q2.30, rounded to q1.14
   function automatic logic [ROM_BITS-1:0] build_sine_rom();
      logic [ROM_BITS-1:0] rom;
      logic [63:0]         theta;
      logic [63:0]         x2;
      logic [63:0]         term;
      longint              sum;
      rom = '0;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         theta = (PI_HALF_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
         x2    = (theta * theta) >> 30;
         sum   = longint'(theta);
         term  = ((theta * x2) >> 30) / 64'd6;
         sum   = sum - longint'(term);
         term  = ((term * x2) >> 30) / 64'd20;
         sum   = sum + longint'(term);
         term  = ((term * x2) >> 30) / 64'd42;
         sum   = sum - longint'(term);
         term  = ((term * x2) >> 30) / 64'd72;
         sum   = sum + longint'(term);
         term  = ((term * x2) >> 30) / 64'd110;
         sum   = sum - longint'(term);
         term  = ((term * x2) >> 30) / 64'd156;
         sum   = sum + longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         rom[k*SIN_W +: SIN_W] = SIN_W'((64'(sum) + 64'd32768) >> 16);
      end
      return rom;
   endfunction

   localparam logic [ROM_BITS-1:0] SINE_ROM = build_sine_rom();

endpackage

@@ hdl/axis_vertex_rotator_unit.sv @@
// top level of the axis vertex rotator
// depends on avr_pkg, avr_front, avr_fifo and avr_back

// Request channel (req_*): op 0 is a tick that advances the running angle by
// angle_step hundredths of a degree and returns nothing; op 1 is a vertex in
// signed q2.14 that is rotated about the selected axis by the current angle.
// Response channel (rsp_*): one rotated, rounded and saturated vertex per
// vertex request (unchanged for the pass axis, 3), in request order.
// csr_wr_en/csr_index/csr_wdata write axis (index 0) and angle_step (index 1)
// while the block is idle.
// Throughput: one request per cycle, ticks and vertices alike, while req_stall
// is low; the rotation path is fully pipelined.
// With an empty queue a vertex goes from the queue write through seven pipeline
// stages and the output register to response valid.
// Reset: the sine table ram is filled from a constant table, one entry per
// cycle; req_stall stays high until the fill is done. Axis resets to z, step
// to 1, angle to 0.
// Receiver stall: the rotation pipeline freezes while a response waits; a
// four-entry queue keeps taking requests until it fills, then req_stall rises.

module axis_vertex_rotator_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_op,
   input  logic signed [avr_pkg::COORD_WIDTH-1:0] req_x_in,
   input  logic signed [avr_pkg::COORD_WIDTH-1:0] req_y_in,
   input  logic signed [avr_pkg::COORD_WIDTH-1:0] req_z_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [avr_pkg::COORD_WIDTH-1:0] rsp_x_out,
   output logic signed [avr_pkg::COORD_WIDTH-1:0] rsp_y_out,
   output logic signed [avr_pkg::COORD_WIDTH-1:0] rsp_z_out,
   input  logic                                   csr_wr_en,
   input  logic [avr_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [avr_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   import avr_pkg::*;

   logic              fill_busy;
   logic              queue_full;
   logic              queue_empty;
   logic              push;
   logic              pop;
   vertex_type        push_data;
   vertex_type        pop_data;
   logic [AXIS_W-1:0] axis;

   avr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_op     (req_op),
      .req_x_in   (req_x_in),
      .req_y_in   (req_y_in),
      .req_z_in   (req_z_in),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fill_busy  (fill_busy),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data),
      .axis       (axis)
   );

   avr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   avr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .axis        (axis),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .fill_busy   (fill_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_x_out   (rsp_x_out),
      .rsp_y_out   (rsp_y_out),
      .rsp_z_out   (rsp_z_out)
   );

endmodule

@@ hdl/avr_ram.sv @@
// generic ram: one write port, two read ports with registered read data
// no dependencies

module avr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ hdl/avr_fifo.sv @@
// short vertex queue between the front end and the rotation pipeline
// depends on avr_pkg

module avr_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  avr_pkg::vertex_type push_data,
   input  logic               pop,
   output avr_pkg::vertex_type pop_data,
   output logic               full,
   output logic               empty
);

   import avr_pkg::*;

   vertex_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);

endmodule

@@ hdl/avr_front.sv @@
// front end: request channel, configuration registers and running angle
// depends on avr_pkg; feeds vertices into avr_fifo

module avr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic signed [avr_pkg::COORD_WIDTH-1:0] req_x_in,
   input  logic signed [avr_pkg::COORD_WIDTH-1:0] req_y_in,
   input  logic signed [avr_pkg::COORD_WIDTH-1:0] req_z_in,
   input  logic                                csr_wr_en,
   input  logic [avr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [avr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                fill_busy,
   input  logic                                queue_full,
   output logic                                push,
   output avr_pkg::vertex_type                 push_data,
   output logic [avr_pkg::AXIS_W-1:0]          axis
);

   import avr_pkg::*;

   logic [AXIS_W-1:0]  axis_ff;
   logic [STEP_W-1:0]  angle_step_ff;
   logic [ANGLE_W-1:0] angle_ff;
   logic [ANGLE_W-1:0] angle_in;
   logic [ANGLE_W:0]   angle_sum;
   logic               accept;

   assign req_stall = queue_full || fill_busy;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (req_op == OP_VERTEX);

   assign angle_sum = {1'b0, angle_ff} + {1'b0, angle_step_ff};
   assign angle_in  = (angle_sum > (ANGLE_W+1)'(FULL_TURN)) ? '0 : angle_sum[ANGLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff       <= AXIS_Z;
         angle_step_ff <= STEP_W'(1);
         angle_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_AXIS:       axis_ff       <= csr_wdata[AXIS_W-1:0];
               CSR_ANGLE_STEP: angle_step_ff <= csr_wdata[STEP_W-1:0];
            endcase
         end
         if (accept && (req_op == OP_TICK)) begin
            angle_ff <= angle_in;
         end
      end
   end

   always_comb begin
      push_data.x     = req_x_in;
      push_data.y     = req_y_in;
      push_data.z     = req_z_in;
      push_data.angle = angle_ff;
   end

   assign axis = axis_ff;

endmodule

@@ hdl/avr_back.sv @@
// back end: angle to table index, sine table lookup, rotation and saturation
// depends on avr_pkg and avr_ram; pulls vertices from avr_fifo

module avr_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [avr_pkg::AXIS_W-1:0]             axis,
   input  logic                                   queue_empty,
   input  avr_pkg::vertex_type                    pop_data,
   output logic                                   pop,
   output logic                                   fill_busy,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [avr_pkg::COORD_WIDTH-1:0] rsp_x_out,
   output logic signed [avr_pkg::COORD_WIDTH-1:0] rsp_y_out,
   output logic signed [avr_pkg::COORD_WIDTH-1:0] rsp_z_out
);

   import avr_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int PROD_W = CW + TRIG_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int PR_W   = NUM_W + RECIP_W;

   localparam logic signed [SUM_W:0] ROUND_HALF = (SUM_W+1)'(1 << (FRAC_BITS - 1));
   localparam logic signed [SUM_W:0] SAT_HI =
      (SUM_W+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [SUM_W:0] SAT_LO = -SAT_HI - (SUM_W+1)'(1);

   function automatic logic signed [CW-1:0] round_sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W:0] b;
      logic signed [SUM_W:0] r;
      b = {v[SUM_W-1], v} + ROUND_HALF;
      r = b >>> FRAC_BITS;
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[CW-1:0];
   endfunction

   // table fill after reset
   logic             fill_active_ff;
   logic [IDX_W-1:0] fill_cnt_ff;
   logic             fill_we_ff;
   logic [IDX_W-1:0] fill_addr_ff;
   logic [SIN_W-1:0] fill_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_active_ff <= 1'b1;
         fill_cnt_ff    <= '0;
         fill_we_ff     <= 1'b0;
      end else begin
         fill_we_ff <= fill_active_ff;
         if (fill_active_ff) begin
            fill_cnt_ff <= fill_cnt_ff + IDX_W'(1);
            if (fill_cnt_ff == IDX_W'(SINE_TABLE_DEPTH)) begin
               fill_active_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      fill_addr_ff <= fill_cnt_ff;
      fill_data_ff <= SINE_ROM[fill_cnt_ff*SIN_W +: SIN_W];
   end

   assign fill_busy = fill_active_ff || fill_we_ff;

   // pipeline advance
   logic adv;
   logic rsp_valid_ff;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign pop = adv && !queue_empty;

   // stage 1: quadrant and remainder
   logic                          s1_valid_ff;
   logic signed [CW-1:0]          s1_x_ff, s1_y_ff, s1_z_ff;
   logic [1:0]                    s1_quad_ff;
   logic [REM_W-1:0]              s1_rem_ff;
   logic [1:0]                    s1_quad_in;
   logic [ANGLE_W-1:0]            s1_base_in;

   always_comb begin
      if (pop_data.angle >= ANGLE_W'(3 * QUARTER_TURN)) begin
         s1_quad_in = 2'd3;
         s1_base_in = ANGLE_W'(3 * QUARTER_TURN);
      end else if (pop_data.angle >= ANGLE_W'(2 * QUARTER_TURN)) begin
         s1_quad_in = 2'd2;
         s1_base_in = ANGLE_W'(2 * QUARTER_TURN);
      end else if (pop_data.angle >= ANGLE_W'(QUARTER_TURN)) begin
         s1_quad_in = 2'd1;
         s1_base_in = ANGLE_W'(QUARTER_TURN);
      end else begin
         s1_quad_in = 2'd0;
         s1_base_in = '0;
      end
   end

   // stage 2: scaled remainder with rounding offset
   logic                 s2_valid_ff;
   logic signed [CW-1:0] s2_x_ff, s2_y_ff, s2_z_ff;
   logic [1:0]           s2_quad_ff;
   logic [NUM_W-1:0]     s2_num_ff;

   // stage 3: reciprocal estimate of the index
   logic                 s3_valid_ff;
   logic signed [CW-1:0] s3_x_ff, s3_y_ff, s3_z_ff;
   logic [1:0]           s3_quad_ff;
   logic [NUM_W-1:0]     s3_num_ff;
   logic [IDX_W-1:0]     s3_est_ff;
   logic [PR_W-1:0]      s3_prod_in;

   assign s3_prod_in = PR_W'(s2_num_ff) * PR_W'(RECIP);

   // stage 4: corrected index
   logic                 s4_valid_ff;
   logic signed [CW-1:0] s4_x_ff, s4_y_ff, s4_z_ff;
   logic [1:0]           s4_quad_ff;
   logic [IDX_W-1:0]     s4_idx_ff;
   logic [NUM_W-1:0]     s4_back_in;
   logic [NUM_W-1:0]     s4_left_in;
   logic [IDX_W-1:0]     s4_idx_in;

   always_comb begin
      s4_back_in = NUM_W'(s3_est_ff) * NUM_W'(QUARTER_TURN);
      s4_left_in = s3_num_ff - s4_back_in;
      s4_idx_in  = (s4_left_in >= NUM_W'(QUARTER_TURN)) ? s3_est_ff + IDX_W'(1) : s3_est_ff;
   end

   // table read at the sine and cosine addresses
   logic [IDX_W-1:0] sin_addr;
   logic [IDX_W-1:0] cos_addr;
   logic [IDX_W-1:0] mirror_idx;
   logic [SIN_W-1:0] sin_mag;
   logic [SIN_W-1:0] cos_mag;

   assign mirror_idx = IDX_W'(SINE_TABLE_DEPTH) - s4_idx_ff;
   assign sin_addr   = s4_quad_ff[0] ? mirror_idx : s4_idx_ff;
   assign cos_addr   = s4_quad_ff[0] ? s4_idx_ff : mirror_idx;

   avr_ram #(
      .WIDTH(SIN_W),
      .DEPTH(SINE_TABLE_DEPTH + 1)
   ) u_sine_ram (
      .clock     (clock),
      .wr_en     (fill_we_ff),
      .wr_addr   (fill_addr_ff),
      .wr_data   (fill_data_ff),
      .rd_en     (adv),
      .rd_addr_a (sin_addr),
      .rd_addr_b (cos_addr),
      .rd_data_a (sin_mag),
      .rd_data_b (cos_mag)
   );

   // stage 5: table data arrives, signs applied, operands chosen
   logic                     s5_valid_ff;
   logic signed [CW-1:0]     s5_x_ff, s5_y_ff, s5_z_ff;
   logic                     s5_sin_neg_ff;
   logic                     s5_cos_neg_ff;
   logic signed [TRIG_W-1:0] s5_sin_in;
   logic signed [TRIG_W-1:0] s5_cos_in;
   logic signed [CW-1:0]     s5_a_in;
   logic signed [CW-1:0]     s5_b_in;

   always_comb begin
      s5_sin_in = s5_sin_neg_ff ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      s5_cos_in = s5_cos_neg_ff ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
      case (axis)
         AXIS_X: begin
            s5_a_in = s5_y_ff;
            s5_b_in = s5_z_ff;
         end
         AXIS_Y: begin
            s5_a_in = s5_z_ff;
            s5_b_in = s5_x_ff;
         end
         default: begin
            s5_a_in = s5_x_ff;
            s5_b_in = s5_y_ff;
         end
      endcase
   end

   // stage 6: operands registered
   logic                     s6_valid_ff;
   logic signed [CW-1:0]     s6_x_ff, s6_y_ff, s6_z_ff;
   logic signed [CW-1:0]     s6_a_ff, s6_b_ff;
   logic signed [TRIG_W-1:0] s6_sin_ff, s6_cos_ff;

   // stage 7: products
   logic                     s7_valid_ff;
   logic signed [CW-1:0]     s7_x_ff, s7_y_ff, s7_z_ff;
   logic signed [PROD_W-1:0] s7_ac_ff, s7_bs_ff, s7_as_ff, s7_bc_ff;

   // output: sums, rounding and saturation
   logic signed [SUM_W-1:0] first_sum;
   logic signed [SUM_W-1:0] second_sum;
   logic signed [CW-1:0]    first_out;
   logic signed [CW-1:0]    second_out;
   logic signed [CW-1:0]    rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic signed [CW-1:0]    rsp_x_in, rsp_y_in, rsp_z_in;

   always_comb begin
      first_sum  = SUM_W'(s7_ac_ff) - SUM_W'(s7_bs_ff);
      second_sum = SUM_W'(s7_as_ff) + SUM_W'(s7_bc_ff);
      first_out  = round_sat(first_sum);
      second_out = round_sat(second_sum);
      rsp_x_in   = s7_x_ff;
      rsp_y_in   = s7_y_ff;
      rsp_z_in   = s7_z_ff;
      case (axis)
         AXIS_X: begin
            rsp_y_in = first_out;
            rsp_z_in = second_out;
         end
         AXIS_Y: begin
            rsp_z_in = first_out;
            rsp_x_in = second_out;
         end
         AXIS_Z: begin
            rsp_x_in = first_out;
            rsp_y_in = second_out;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         rsp_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff    <= pop_data.x;
         s1_y_ff    <= pop_data.y;
         s1_z_ff    <= pop_data.z;
         s1_quad_ff <= s1_quad_in;
         s1_rem_ff  <= REM_W'(pop_data.angle - s1_base_in);

         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_z_ff    <= s1_z_ff;
         s2_quad_ff <= s1_quad_ff;
         s2_num_ff  <= NUM_W'(s1_rem_ff) * NUM_W'(SINE_TABLE_DEPTH) + NUM_W'(QUARTER_TURN / 2);

         s3_x_ff    <= s2_x_ff;
         s3_y_ff    <= s2_y_ff;
         s3_z_ff    <= s2_z_ff;
         s3_quad_ff <= s2_quad_ff;
         s3_num_ff  <= s2_num_ff;
         s3_est_ff  <= IDX_W'(s3_prod_in >> RECIP_SHIFT);

         s4_x_ff    <= s3_x_ff;
         s4_y_ff    <= s3_y_ff;
         s4_z_ff    <= s3_z_ff;
         s4_quad_ff <= s3_quad_ff;
         s4_idx_ff  <= s4_idx_in;

         s5_x_ff       <= s4_x_ff;
         s5_y_ff       <= s4_y_ff;
         s5_z_ff       <= s4_z_ff;
         s5_sin_neg_ff <= s4_quad_ff[1];
         s5_cos_neg_ff <= s4_quad_ff[1] ^ s4_quad_ff[0];

         s6_x_ff   <= s5_x_ff;
         s6_y_ff   <= s5_y_ff;
         s6_z_ff   <= s5_z_ff;
         s6_a_ff   <= s5_a_in;
         s6_b_ff   <= s5_b_in;
         s6_sin_ff <= s5_sin_in;
         s6_cos_ff <= s5_cos_in;

         s7_x_ff  <= s6_x_ff;
         s7_y_ff  <= s6_y_ff;
         s7_z_ff  <= s6_z_ff;
         s7_ac_ff <= PROD_W'(s6_a_ff) * PROD_W'(s6_cos_ff);
         s7_bs_ff <= PROD_W'(s6_b_ff) * PROD_W'(s6_sin_ff);
         s7_as_ff <= PROD_W'(s6_a_ff) * PROD_W'(s6_sin_ff);
         s7_bc_ff <= PROD_W'(s6_b_ff) * PROD_W'(s6_cos_ff);

         rsp_x_ff <= rsp_x_in;
         rsp_y_ff <= rsp_y_in;
         rsp_z_ff <= rsp_z_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_out = rsp_x_ff;
   assign rsp_y_out = rsp_y_ff;
   assign rsp_z_out = rsp_z_ff;

endmodule

@@ bench/tb_top.sv @@
// testbench for axis_vertex_rotator_unit: ticks and vertices with random gaps and stalls
// a scoreboard class predicts each rotated vertex; depends on avr_pkg and the rtl only
`timescale 1ns / 1ps

module tb_top;
   import avr_pkg::*;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } coord_triple_type;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   class rotation_scoreboard;
      int unsigned       sine_quarter[SINE_TABLE_DEPTH+1];
      logic [AXIS_W-1:0] axis_sel;
      int unsigned       step;
      int unsigned       angle;
      coord_triple_type  expected_vertices[$];
      int                error_count;

      function new();
         longint unsigned theta;
         longint unsigned x2;
         longint unsigned term;
         longint          sum;
         for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            theta = (HALF_PI_Q30 * longint'(k)) / longint'(SINE_TABLE_DEPTH);
            x2    = (theta * theta) >> 30;
            term  = theta;
            sum   = longint'(theta);
            for (int n = 1; n <= 6; n++) begin
               term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
            if (sum < 0) begin
               sum = 0;
            end
            sine_quarter[k] = int'((sum + 32768) >>> 16);
         end
         axis_sel    = AXIS_Z;
         step        = 1;
         angle       = 0;
         error_count = 0;
      endfunction

      function longint quarter_wave(int unsigned quadrant, int unsigned idx);
         int unsigned q;
         longint      v;
         q = quadrant & 3;
         v = (q & 1) ? longint'(sine_quarter[SINE_TABLE_DEPTH - idx]) :
                       longint'(sine_quarter[idx]);
         return (q & 2) ? -v : v;
      endfunction

      function logic signed [COORD_WIDTH-1:0] round_saturate(longint v);
         longint hi;
         longint lo;
         longint r;
         hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
         lo = -hi - 1;
         r  = (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         if (r > hi) begin
            r = hi;
         end else if (r < lo) begin
            r = lo;
         end
         return r[COORD_WIDTH-1:0];
      endfunction

      function coord_triple_type rotate_vertex(coord_triple_type v);
         int unsigned      quadrant;
         int unsigned      rem;
         int unsigned      idx;
         longint           s;
         longint           c;
         longint           x;
         longint           y;
         longint           z;
         coord_triple_type r;
         quadrant = angle / QUARTER_TURN;
         rem      = angle % QUARTER_TURN;
         idx      = (rem * SINE_TABLE_DEPTH + QUARTER_TURN / 2) / QUARTER_TURN;
         s        = quarter_wave(quadrant, idx);
         c        = quarter_wave(quadrant + 1, idx);
         x        = longint'(v.x);
         y        = longint'(v.y);
         z        = longint'(v.z);
         r        = v;
         case (axis_sel)
            AXIS_X: begin
               r.y = round_saturate(y * c - z * s);
               r.z = round_saturate(y * s + z * c);
            end
            AXIS_Y: begin
               r.x = round_saturate(x * c + z * s);
               r.z = round_saturate(z * c - x * s);
            end
            AXIS_Z: begin
               r.x = round_saturate(x * c - y * s);
               r.y = round_saturate(x * s + y * c);
            end
            default: begin
            end
         endcase
         return r;
      endfunction

      function void write_setting(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_AXIS) begin
            axis_sel = data[AXIS_W-1:0];
         end else if (index == CSR_ANGLE_STEP) begin
            step = 32'(data);
         end
      endfunction

      function void note_request(logic op, coord_triple_type v);
         int unsigned sum;
         if (op == OP_TICK) begin
            sum   = angle + step;
            angle = (sum > FULL_TURN) ? 0 : sum;
         end else begin
            expected_vertices.push_back(rotate_vertex(v));
         end
      endfunction

      task report_mismatch(string what);
         $display("ERROR at %0t: %s", $time, what);
         error_count++;
      endtask

      task check_response(coord_triple_type got);
         coord_triple_type want;
         if (expected_vertices.size() == 0) begin
            report_mismatch($sformatf("response with none pending (%0d %0d %0d)",
                                      got.x, got.y, got.z));
         end else begin
            want = expected_vertices.pop_front();
            if (got.x !== want.x) begin
               report_mismatch($sformatf("x_out %0d, predicted %0d", got.x, want.x));
            end
            if (got.y !== want.y) begin
               report_mismatch($sformatf("y_out %0d, predicted %0d", got.y, want.y));
            end
            if (got.z !== want.z) begin
               report_mismatch($sformatf("z_out %0d, predicted %0d", got.z, want.z));
            end
         end
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_op;
   logic signed [COORD_WIDTH-1:0] req_x_in;
   logic signed [COORD_WIDTH-1:0] req_y_in;
   logic signed [COORD_WIDTH-1:0] req_z_in;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [COORD_WIDTH-1:0] rsp_x_out;
   logic signed [COORD_WIDTH-1:0] rsp_y_out;
   logic signed [COORD_WIDTH-1:0] rsp_z_out;
   logic                          csr_wr_en;
   logic [CSR_INDEX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]         csr_wdata;

   rotation_scoreboard rotation_check = new();

   bit          sender_idling   = 1;
   bit          receiver_idling = 1;
   bit          hold_request    = 0;
   int unsigned hold_length     = 0;

   axis_vertex_rotator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_x_in  (req_x_in),
      .req_y_in  (req_y_in),
      .req_z_in  (req_z_in),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_x_out (rsp_x_out),
      .rsp_y_out (rsp_y_out),
      .rsp_z_out (rsp_z_out),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

   // mostly short runs, now and then a long one
   function automatic int unsigned random_run();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 10) begin
         return 0;
      end else if (r < 18) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic coord_triple_type make_vertex(int x, int y, int z);
      coord_triple_type v;
      v.x = x[COORD_WIDTH-1:0];
      v.y = y[COORD_WIDTH-1:0];
      v.z = z[COORD_WIDTH-1:0];
      return v;
   endfunction

   function automatic int random_coord();
      int unsigned r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 32767;
         1: return -32768;
         2: return int'($urandom_range(0, 64)) - 32;
         default: return int'($urandom());
      endcase
   endfunction

   // sampled at the rising edge; the check runs before the new transfer is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rotation_check.check_response(
               coord_triple_type'{rsp_x_out, rsp_y_out, rsp_z_out});
         end
         if (req_valid && !req_stall) begin
            rotation_check.note_request(req_op,
               coord_triple_type'{req_x_in, req_y_in, req_z_in});
         end
      end
   end

   initial begin
      int unsigned run;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (hold_length) @(negedge clock);
            hold_request = 0;
            rsp_stall    = 1'b0;
         end else if (!receiver_idling) begin
            rsp_stall = 1'b0;
         end else begin
            run       = 1 + random_run();
            rsp_stall = ($urandom_range(0, 2) == 0);
            repeat (run - 1) @(negedge clock);
         end
      end
   end

   task automatic send_item(logic op, coord_triple_type v);
      int unsigned gap;
      gap = sender_idling ? random_run() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_op    = op;
      req_x_in  = v.x;
      req_y_in  = v.y;
      req_z_in  = v.z;
      do @(posedge clock); while (req_stall);
   endtask

   // ticks leave nothing to wait for, so allow the pipeline to drain too
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (rotation_check.expected_vertices.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      rotation_check.write_setting(index, data);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      logic [AXIS_W-1:0] axis_codes[4];
      logic [AXIS_W-1:0] axis_plan[8];
      int unsigned       step_plan[8];
      logic              op;

      axis_codes = '{AXIS_X, AXIS_Y, AXIS_Z, AXIS_PASS};
      axis_plan  = '{AXIS_X, AXIS_Y, AXIS_Z, AXIS_PASS, AXIS_Z, AXIS_X, AXIS_Y, AXIS_Z};
      step_plan  = '{1, 36000, 0, $urandom_range(0, 36000), 65535, 9000,
                     $urandom_range(1, 999), $urandom_range(0, 65535)};

      reset     = 1'b1;
      req_valid = 1'b0;
      req_op    = OP_TICK;
      req_x_in  = '0;
      req_y_in  = '0;
      req_z_in  = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_AXIS;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // sine table fill after reset
      do @(posedge clock); while (req_stall);

      // directed: reset settings, extremes, every axis, wrap and full turn
      send_item(OP_VERTEX, make_vertex(32767, -32768, 1));
      send_item(OP_TICK, make_vertex(-1, -1, -1));
      send_item(OP_VERTEX, make_vertex(-32768, 32767, -32768));
      wait_idle();
      write_register(CSR_ANGLE_STEP, 16'd4500);
      foreach (axis_codes[a]) begin
         wait_idle();
         write_register(CSR_AXIS, CSR_DATA_W'(axis_codes[a]));
         send_item(OP_VERTEX, make_vertex(32767, -32768, 32767));
         send_item(OP_TICK, make_vertex(0, 0, 0));
         send_item(OP_VERTEX, make_vertex(-32768, 32767, -32768));
      end
      wait_idle();
      write_register(CSR_AXIS, CSR_DATA_W'(AXIS_Z));
      write_register(CSR_ANGLE_STEP, 16'hFFFF);
      send_item(OP_TICK, make_vertex(0, 0, 0));
      wait_idle();
      write_register(CSR_ANGLE_STEP, 16'd9000);
      repeat (4) send_item(OP_TICK, make_vertex(0, 0, 0));
      send_item(OP_VERTEX, make_vertex(16384, -16384, 5));
      send_item(OP_TICK, make_vertex(0, 0, 0));
      send_item(OP_VERTEX, make_vertex(32767, 32767, -32768));
      wait_idle();
      write_register(CSR_ANGLE_STEP, 16'd0);
      send_item(OP_TICK, make_vertex(0, 0, 0));
      send_item(OP_VERTEX, make_vertex(-16384, 12345, 0));

      // random phases, one setting each
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         write_register(CSR_AXIS, CSR_DATA_W'(axis_plan[p]));
         write_register(CSR_ANGLE_STEP, CSR_DATA_W'(step_plan[p]));
         sender_idling   = !(p == 1 || p == 2 || p == 5);
         receiver_idling = (p != 2);
         for (int n = 0; n < 90; n++) begin
            if (p == 1 && n == 20) begin
               hold_length  = 150;
               hold_request = 1;
            end
            op = ($urandom_range(0, 99) < 30) ? OP_TICK : OP_VERTEX;
            send_item(op, make_vertex(random_coord(), random_coord(), random_coord()));
         end
      end

      sender_idling = 1;
      @(negedge clock);
      req_valid = 1'b0;
      while (rotation_check.expected_vertices.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (rotation_check.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
